// ----- design/lkvt_pkg.sv -----
`default_nettype none

package lkvt_pkg;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_ACCESS = 3'd1,
        OP_WRITE  = 3'd2,
        OP_DELETE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    // Update command from the sequencer to the slot store.
    typedef struct packed {
        logic en;
        logic set_used;
        logic clr_used;
        logic clr_all;
    } wr_cmd_t;

endpackage

`default_nettype wire

// ----- design/lkvt_store.sv -----
`default_nettype none

module lkvt_store #(
    parameter int CAPACITY = 16,
    parameter int IW       = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [IW-1:0]     rd_addr,
    output logic                   rd_used,
    output logic [31:0]            rd_key,
    output logic [31:0]            rd_value,
    input  wire lkvt_pkg::wr_cmd_t wr_cmd,
    input  wire logic [IW-1:0]     wr_addr,
    input  wire logic [31:0]       wr_key,
    input  wire logic [31:0]       wr_value
);
    import lkvt_pkg::*;

    logic [CAPACITY-1:0] used_reg;
    logic [31:0]         key_mem [CAPACITY];
    logic [31:0]         value_mem [CAPACITY];
    logic                rd_used_reg;
    logic [31:0]         rd_key_reg;
    logic [31:0]         rd_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            rd_used_reg <= 1'b0;
        end
        else
        begin
            rd_used_reg <= used_reg[rd_addr];
            if (wr_cmd.clr_all)
            begin
                used_reg <= '0;
            end
            else if (wr_cmd.set_used)
            begin
                used_reg[wr_addr] <= 1'b1;
            end
            else if (wr_cmd.clr_used)
            begin
                used_reg[wr_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
        if (wr_cmd.en)
        begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
    end

    assign rd_used  = rd_used_reg;
    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

`default_nettype wire

// ----- design/linear_key_value_table_unit.sv -----
`default_nettype none
// Read, access, write and delete scan every slot in the SCAN state, then pass DRAIN and COMMIT;
// clear and unused op codes go straight from IDLE to COMMIT.
// Throughput: one request at a time; the slot scan reads one stored slot per cycle
// through the single read port of the key and value memories.
// Reset clears the valid bits, the entry count and all control state at once;
// key and value memories are not cleared.

module linear_key_value_table_unit #(
    parameter int CAPACITY = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire logic [2:0]         op,
    input  wire logic [31:0]        key,
    input  wire logic signed [31:0] value,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output logic signed [31:0]      value_out,
    output logic                    found,
    output logic [4:0]              entry_count,
    output logic                    full_refused
);
    import lkvt_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    state_t state_reg, state_next;

    logic [IW-1:0] idx_reg;
    logic          cmp_valid_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic [2:0]    op_reg;
    logic [31:0]   key_reg;
    logic [31:0]   value_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [31:0]   hit_value_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic [CW-1:0] count_reg, count_next;

    logic          rsp_valid_reg;
    logic [31:0]   value_out_reg, value_out_next;
    logic          found_reg, found_next;
    logic          refused_reg, refused_next;

    logic          accept;
    logic          scan_issue;
    logic          commit_fire;
    logic          is_search;

    logic          rd_used;
    logic [31:0]   rd_key;
    logic [31:0]   rd_value;
    wr_cmd_t       wr_cmd;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_key;
    logic [31:0]   wr_value;

    lkvt_store #(
        .CAPACITY(CAPACITY),
        .IW      (IW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (idx_reg),
        .rd_used (rd_used),
        .rd_key  (rd_key),
        .rd_value(rd_value),
        .wr_cmd  (wr_cmd),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_value(wr_value)
    );

    assign is_search = (op == OP_READ) || (op == OP_ACCESS) || (op == OP_WRITE)
                       || (op == OP_DELETE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = is_search ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        scan_issue  = 1'b0;
        commit_fire = 1'b0;
        case (state_reg)
            ST_IDLE:   req_ready   = 1'b1;
            ST_SCAN:   scan_issue  = 1'b1;
            ST_COMMIT: commit_fire = !rsp_valid_reg || rsp_ready;
            default:   req_ready   = 1'b0;
        endcase
    end

    assign accept = req_valid && req_ready;

    // Decide the table update and the result in COMMIT, after the scan has seen every slot for a search op.
    always_comb
    begin
        wr_cmd         = '0;
        wr_addr        = hit_idx_reg;
        wr_key         = key_reg;
        wr_value       = value_reg;
        count_next     = count_reg;
        value_out_next = 32'd0;
        found_next     = 1'b0;
        refused_next   = 1'b0;
        case (op_reg)
            OP_READ:
            begin
                found_next     = hit_reg;
                value_out_next = hit_reg ? hit_value_reg : 32'd0;
            end
            OP_ACCESS, OP_WRITE:
            begin
                if (hit_reg)
                begin
                    found_next = 1'b1;
                    if (op_reg == OP_WRITE)
                    begin
                        wr_cmd.en      = commit_fire;
                        value_out_next = value_reg;
                    end
                    else
                    begin
                        value_out_next = hit_value_reg;
                    end
                end
                else if (free_reg)
                begin
                    wr_addr         = free_idx_reg;
                    wr_value        = (op_reg == OP_WRITE) ? value_reg : 32'd0;
                    wr_cmd.en       = commit_fire;
                    wr_cmd.set_used = commit_fire;
                    count_next      = count_reg + CW'(1);
                    value_out_next  = wr_value;
                end
                else
                begin
                    refused_next = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (hit_reg)
                begin
                    found_next      = 1'b1;
                    wr_cmd.clr_used = commit_fire;
                    count_next      = count_reg - CW'(1);
                end
            end
            OP_CLEAR:
            begin
                wr_cmd.clr_all = commit_fire;
                count_next     = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= scan_issue;
            if (accept)
            begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else
            begin
                if (scan_issue)
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
                if (cmp_valid_reg)
                begin
                    if (rd_used && (rd_key == key_reg) && !hit_reg)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (!rd_used && !free_reg)
                    begin
                        free_reg <= 1'b1;
                    end
                end
            end
            if (commit_fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= idx_reg;
        if (accept)
        begin
            op_reg    <= op;
            key_reg   <= key;
            value_reg <= value;
        end
        if (cmp_valid_reg && !accept)
        begin
            if (rd_used && (rd_key == key_reg) && !hit_reg)
            begin
                hit_idx_reg   <= cmp_idx_reg;
                hit_value_reg <= rd_value;
            end
            if (!rd_used && !free_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
        if (commit_fire)
        begin
            value_out_reg <= value_out_next;
            found_reg     <= found_next;
            refused_reg   <= refused_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign value_out    = value_out_reg;
    assign found        = found_reg;
    assign entry_count  = 5'(count_reg);
    assign full_refused = refused_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("entry count exceeds capacity");

    a_free_when_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && (op_reg == OP_ACCESS || op_reg == OP_WRITE)
         && !hit_reg && count_reg < CAP_COUNT) |-> free_reg)
        else $error("scan missed a free slot while the table is not full");

    a_refused_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(found_reg && refused_reg))
        else $error("result flags both found and refused");

    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit_fire && op_reg == OP_DELETE && hit_reg)
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("delete of a present key did not lower the count");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvt_pkg::*;

    localparam int TABLE_SLOTS = 16;
    localparam int RANDOM_REQUESTS = 1650;
    localparam int POOL_DEPTH = 32;
    localparam int POOL_REFRESH = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;

    typedef struct packed {
        logic [31:0] value_out;
        logic        found;
        logic [4:0]  entry_count;
        logic        full_refused;
    } table_result_t;

    typedef struct packed {
        logic [2:0]    op;
        logic [31:0]   key;
        logic [31:0]   value;
        bit            typed;
        table_result_t result;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [2:0]         op = '0;
    logic [31:0]        key = '0;
    logic signed [31:0] value = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic signed [31:0] value_out;
    logic               found;
    logic [4:0]         entry_count;
    logic               full_refused;

    // Shadow copy of the table contents.
    bit          model_used [TABLE_SLOTS];
    logic [31:0] model_key [TABLE_SLOTS];
    logic [31:0] model_value [TABLE_SLOTS];
    int          model_count = 0;

    table_result_t pending_results[$];
    stim_row_t     directed_rows[$];
    logic [31:0]   key_pool [POOL_DEPTH];
    int            pool_size = 1;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;
    bit            gaps_on = 1'b1;

    linear_key_value_table_unit #(
        .CAPACITY(TABLE_SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .op(op),
        .key(key),
        .value(value),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .value_out(value_out),
        .found(found),
        .entry_count(entry_count),
        .full_refused(full_refused)
    );

    always #5 clk = ~clk;

    function automatic table_result_t apply_table_op(input logic [2:0] o, input logic [31:0] k,
                                                     input logic [31:0] v);
        table_result_t r;
        int hit;
        int spare;
        r = '0;
        hit = -1;
        spare = -1;
        // Walk downward so that the lowest matching and lowest free slot win.
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (model_used[i] && model_key[i] == k)
                hit = i;
            if (!model_used[i])
                spare = i;
        end
        case (o)
            OP_READ:
            begin
                if (hit >= 0)
                begin
                    r.found = 1'b1;
                    r.value_out = model_value[hit];
                end
            end
            OP_ACCESS, OP_WRITE:
            begin
                if (hit >= 0)
                    r.found = 1'b1;
                else if (spare >= 0)
                begin
                    hit = spare;
                    model_used[hit] = 1'b1;
                    model_key[hit] = k;
                    model_value[hit] = '0;
                    model_count++;
                end
                else
                    r.full_refused = 1'b1;
                if (hit >= 0)
                begin
                    if (o == OP_WRITE)
                        model_value[hit] = v;
                    r.value_out = model_value[hit];
                end
            end
            OP_DELETE:
            begin
                if (hit >= 0)
                begin
                    r.found = 1'b1;
                    model_used[hit] = 1'b0;
                    model_count--;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                    model_used[i] = 1'b0;
                model_count = 0;
            end
            default: ;
        endcase
        r.entry_count = model_count[4:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Holds one request on the bus until it is taken, then records what it should return.
    task automatic drive_request(input logic [2:0] o, input logic [31:0] k, input logic [31:0] v,
                                 input bit typed, input table_result_t typed_result);
        table_result_t predicted;
        if (gaps_on && $urandom_range(99) < 11)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        req_valid <= 1'b1;
        op <= o;
        key <= k;
        value <= v;
        do @(posedge clk); while (req_ready !== 1'b1);
        predicted = apply_table_op(o, k, v);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin : response_side
        int stall_left;
        table_result_t expected;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, actual %h %b %0d %b",
                             $time, value_out, found, entry_count, full_refused);
                    mismatch_count++;
                end
                else
                begin
                    expected = pending_results.pop_front();
                    check_field("value_out", expected.value_out, value_out);
                    check_field("found", 32'(expected.found), 32'(found));
                    check_field("entry_count", 32'(expected.entry_count), 32'(entry_count));
                    check_field("full_refused", 32'(expected.full_refused), 32'(full_refused));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(99) < 3)
            begin
                stall_left = $urandom_range(7);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int pick;
        logic [2:0] o;
        logic [31:0] k;
        logic [31:0] v;

        directed_rows.push_back('{OP_READ, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 5'd0, 1'b0}});
        directed_rows.push_back('{OP_WRITE, 32'h0, 32'h7FFF_FFFF, 1'b1,
                                  '{32'h7FFF_FFFF, 1'b0, 5'd1, 1'b0}});
        directed_rows.push_back('{OP_WRITE, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
                                  '{32'h8000_0000, 1'b0, 5'd2, 1'b0}});
        // Walking-one keys fill the remaining slots.
        for (int i = 0; i < TABLE_SLOTS - 2; i++)
            directed_rows.push_back('{OP_ACCESS, 32'h1 << i, $urandom(), 1'b0, '0});
        directed_rows.push_back('{OP_ACCESS, 32'hAAAA_5555, 32'h0, 1'b1,
                                  '{32'h0, 1'b0, 5'd16, 1'b1}});
        directed_rows.push_back('{OP_WRITE, 32'h5555_AAAA, 32'h1, 1'b1,
                                  '{32'h0, 1'b0, 5'd16, 1'b1}});
        directed_rows.push_back('{OP_READ, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                  '{32'h8000_0000, 1'b1, 5'd16, 1'b0}});
        directed_rows.push_back('{OP_WRITE, 32'h0, 32'hFFFF_FFFF, 1'b1,
                                  '{32'hFFFF_FFFF, 1'b1, 5'd16, 1'b0}});
        directed_rows.push_back('{OP_DELETE, 32'h8, 32'h0, 1'b1, '{32'h0, 1'b1, 5'd15, 1'b0}});
        directed_rows.push_back('{OP_DELETE, 32'h8, 32'h0, 1'b1, '{32'h0, 1'b0, 5'd15, 1'b0}});
        directed_rows.push_back('{OP_ACCESS, 32'h5555_AAAA, 32'h0, 1'b1,
                                  '{32'h0, 1'b0, 5'd16, 1'b0}});
        directed_rows.push_back('{OP_SPARE_FIRST, 32'h0, 32'h0, 1'b1,
                                  '{32'h0, 1'b0, 5'd16, 1'b0}});
        directed_rows.push_back('{OP_SPARE_LAST, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
                                  '{32'h0, 1'b0, 5'd16, 1'b0}});
        directed_rows.push_back('{OP_CLEAR, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 5'd0, 1'b0}});
        // Stale keys stay in the memories after a clear and must not hit.
        directed_rows.push_back('{OP_READ, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                  '{32'h0, 1'b0, 5'd0, 1'b0}});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            drive_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                          directed_rows[i].typed, directed_rows[i].result);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // A fresh key pool now and then; some keys differ from another in one bit only.
            if (n % POOL_REFRESH == 0)
            begin
                pool_size = $urandom_range(2, POOL_DEPTH - 4);
                for (int i = 0; i < POOL_DEPTH; i++)
                    key_pool[i] = ($urandom_range(1) == 0 || i == 0) ? $urandom()
                                  : key_pool[0] ^ (32'h1 << $urandom_range(31));
            end
            gaps_on = !(n >= 700 && n < 950);

            pick = $urandom_range(99);
            if (pick < 22)
                o = OP_READ;
            else if (pick < 38)
                o = OP_ACCESS;
            else if (pick < 66)
                o = OP_WRITE;
            else if (pick < 90)
                o = OP_DELETE;
            else if (pick < 93)
                o = OP_CLEAR;
            else if (pick < 96)
                o = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            else
                o = 3'($urandom_range(7));

            k = ($urandom_range(99) < 88) ? key_pool[$urandom_range(pool_size - 1)] : $urandom();

            pick = $urandom_range(9);
            if (pick == 0)
                v = 32'h8000_0000;
            else if (pick == 1)
                v = 32'h7FFF_FFFF;
            else if (pick == 2)
                v = 32'h0;
            else
                v = $urandom();

            drive_request(o, k, v, 1'b0, '0);
        end
        req_valid <= 1'b0;
        gaps_on = 1'b1;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
